[sv/pdk_pkg.sv]
// package with shared widths, constants and item types of the polygon depth key block
`timescale 1ns / 1ps
`default_nettype none

package pdk_pkg;

   // coordinate width of one vertex axis, signed Q16.16 at 32
   localparam int COORD_WIDTH = 32;
   localparam int OBJ_W       = 4;
   localparam int POLY_W      = 12;
   localparam int KEY_W       = 32;

   // squares and their sum carry twice the coordinate width
   localparam int SQ_W        = 2 * COORD_WIDTH;

   // three axes x, y, z
   localparam int NUM_AXES    = 3;
   localparam int AXIS_W      = $clog2(NUM_AXES);
   localparam int STEP_W      = $clog2(NUM_AXES + 1);

   // bounds queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one vertex item
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic signed [COORD_WIDTH-1:0] z_coord;
      logic [OBJ_W-1:0]              object_tag;
      logic [POLY_W-1:0]             poly_tag;
      logic                          last_vertex;
   } pdk_req_type;

   // one result item
   typedef struct packed {
      logic [KEY_W-1:0]  depth_key;
      logic [OBJ_W-1:0]  object_out;
      logic [POLY_W-1:0] poly_out;
   } pdk_rsp_type;

   // running bounds on one axis
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] low;
      logic signed [COORD_WIDTH-1:0] high;
   } pdk_axis_type;

   // finished polygon handed from front to back
   typedef struct packed {
      pdk_axis_type      x_axis;
      pdk_axis_type      y_axis;
      pdk_axis_type      z_axis;
      logic [OBJ_W-1:0]  object_tag;
      logic [POLY_W-1:0] poly_tag;
   } pdk_entry_type;

endpackage

`default_nettype wire

[sv/pdk_queue.sv]
// short fifo of finished polygon bounds between front and back
`timescale 1ns / 1ps
`default_nettype none

module pdk_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pdk_pkg::pdk_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output pdk_pkg::pdk_entry_type head_entry
);
   import pdk_pkg::*;

   pdk_entry_type      store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] nxt;
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + QPTR_W'(1);
      end
      return nxt;
   endfunction

   // status flags
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

[sv/pdk_front.sv]
// front end: takes vertices and tracks the running bounding box per axis
`timescale 1ns / 1ps
`default_nettype none

module pdk_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pdk_pkg::pdk_req_type   req_item,
   input  logic                   q_full,
   output logic                   q_push,
   output pdk_pkg::pdk_entry_type q_entry
);
   import pdk_pkg::*;

   logic          first_pending_ff;
   pdk_axis_type  x_ff, y_ff, z_ff;
   pdk_axis_type  x_in, y_in, z_in;
   logic          accept;

   function automatic pdk_axis_type take_bounds(
      input pdk_axis_type                  cur,
      input logic signed [COORD_WIDTH-1:0] v,
      input logic                          first
   );
      pdk_axis_type nxt;
      nxt = cur;
      if (first) begin
         nxt.low  = v;
         nxt.high = v;
      end else begin
         if (v < cur.low) begin
            nxt.low = v;
         end
         if (v > cur.high) begin
            nxt.high = v;
         end
      end
      return nxt;
   endfunction

   // hold vertices back only while the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // bounds including the current vertex
   always_comb begin
      x_in = take_bounds(x_ff, req_item.x_coord, first_pending_ff);
      y_in = take_bounds(y_ff, req_item.y_coord, first_pending_ff);
      z_in = take_bounds(z_ff, req_item.z_coord, first_pending_ff);
   end

   // the last vertex closes the polygon and hands its box to the back
   assign q_push             = accept && req_item.last_vertex;
   assign q_entry.x_axis     = x_in;
   assign q_entry.y_axis     = y_in;
   assign q_entry.z_axis     = z_in;
   assign q_entry.object_tag = req_item.object_tag;
   assign q_entry.poly_tag   = req_item.poly_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
      end else if (accept) begin
         first_pending_ff <= req_item.last_vertex;
      end
   end

   // running bounds, no reset: the first vertex always writes them
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

`default_nettype wire

[sv/pdk_back.sv]
// back end: box center, sum of squares and bit-pair square root per polygon
`timescale 1ns / 1ps
`default_nettype none

module pdk_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  pdk_pkg::pdk_entry_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pdk_pkg::pdk_rsp_type   rsp_item
);
   import pdk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [COORD_WIDTH-1:0] mag_ff [NUM_AXES];
   logic [STEP_W-1:0]  step_ff;
   logic [SQ_W-1:0]    prod_ff;
   logic [SQ_W-1:0]    acc_ff;
   logic [SQ_W-1:0]    root_ff;
   logic [SQ_W-1:0]    bit_ff;
   logic [OBJ_W-1:0]   object_ff;
   logic [POLY_W-1:0]  poly_ff;
   logic               rsp_valid_ff;
   pdk_rsp_type        rsp_item_ff;

   logic [COORD_WIDTH-1:0] sq_operand;
   logic [SQ_W-1:0]    sq_product;
   logic [SQ_W-1:0]    trial;
   logic               trial_fits;
   logic [KEY_W-1:0]   key_value;
   logic               rsp_load;

   // magnitude of floor((low + high) / 2)
   function automatic logic [COORD_WIDTH-1:0] center_mag(input pdk_axis_type ax);
      logic signed [COORD_WIDTH:0]   sum;
      logic signed [COORD_WIDTH-1:0] c;
      sum = {ax.low[COORD_WIDTH-1], ax.low} + {ax.high[COORD_WIDTH-1], ax.high};
      c   = sum[COORD_WIDTH:1];
      return c[COORD_WIDTH-1] ? (COORD_WIDTH)'(-c) : (COORD_WIDTH)'(c);
   endfunction

   // one shared squarer, one axis per cycle
   always_comb begin
      sq_operand = '0;
      if (step_ff < STEP_W'(NUM_AXES)) begin
         sq_operand = mag_ff[step_ff[AXIS_W-1:0]];
      end
   end
   assign sq_product = sq_operand * sq_operand;

   // one root digit per cycle
   assign trial      = root_ff + bit_ff;
   assign trial_fits = (acc_ff >= trial);

   // clamp a root that does not fit the key
   assign key_value = (root_ff[SQ_W-1:KEY_W] != '0) ? '1 : root_ff[KEY_W-1:0];

   // result register takes a new item when empty or being drained
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  mag_ff[0] <= center_mag(q_head.x_axis);
                  mag_ff[1] <= center_mag(q_head.y_axis);
                  mag_ff[2] <= center_mag(q_head.z_axis);
                  object_ff <= q_head.object_tag;
                  poly_ff   <= q_head.poly_tag;
                  step_ff   <= '0;
                  state_ff  <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               // square of one axis while the previous one is summed
               prod_ff <= sq_product;
               if (step_ff == '0) begin
                  acc_ff <= '0;
               end else begin
                  acc_ff <= acc_ff + prod_ff;
               end
               if (step_ff == STEP_W'(NUM_AXES)) begin
                  root_ff  <= '0;
                  bit_ff   <= SQ_W'(1) << (SQ_W - 2);
                  state_ff <= ST_ROOT;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_ROOT: begin
               if (trial_fits) begin
                  acc_ff  <= acc_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_item_ff.depth_key  <= key_value;
                  rsp_item_ff.object_out <= object_ff;
                  rsp_item_ff.poly_out   <= poly_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> $onehot(bit_ff))
      else $error("root bit lost its single set bit");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> (step_ff <= STEP_W'(NUM_AXES)))
      else $error("square step past last axis");
`endif

endmodule

`default_nettype wire

[sv/polygon_depth_key_core.sv]
// Vertices are taken one per cycle while the bounds queue has room; the back end
// works on one polygon at a time in steps (pop, four squaring steps, 32 root steps,
// output load), most of them spent in the bit-pair root iteration. A two-entry bounds
// queue absorbs polygons meanwhile.
// Reset is synchronous and active high; it clears control state only.
`timescale 1ns / 1ps
`default_nettype none

module polygon_depth_key_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pdk_pkg::pdk_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pdk_pkg::pdk_rsp_type rsp_item
);
   import pdk_pkg::*;

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   pdk_entry_type q_entry;
   pdk_entry_type q_head;

   // vertex intake and bounding box
   pdk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // finished boxes waiting for the back end
   pdk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_entry (q_head)
   );

   // center, distance and result register
   pdk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[tb/sv/polygon_depth_key_core_test.sv]
// testbench for the polygon depth key core: directed and random vertex streams
`timescale 1ns / 1ps

module polygon_depth_key_core_test;
   import pdk_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam int     ONE_Q16      = 65536;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     QUIET_LIMIT  = 4000;
   localparam int     DRAIN_CYCLES = 100;

   // scoreboard: tracks the bounding box of the open polygon and the keys due
   class depth_key_board;
      coord_type   box_low[3];
      coord_type   box_high[3];
      bit          opens_polygon;
      pdk_rsp_type keys_due[$];
      int          failures;

      function new();
         opens_polygon = 1'b1;
         failures = 0;
      endfunction

      // floor of the distance of the box center from the origin, saturated
      function logic [KEY_W-1:0] depth_of_box();
         logic signed [COORD_WIDTH:0] center;
         logic [127:0]                mag;
         logic [127:0]                sq_sum;
         logic [127:0]                root;
         logic [127:0]                trial;
         sq_sum = '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            center = box_low[a];
            center = center + box_high[a];
            center = center >>> 1;
            if (center < 0) begin
               center = -center;
            end
            mag = center;
            sq_sum = sq_sum + mag * mag;
         end
         if ((sq_sum >> (2 * KEY_W)) != 0) begin
            return '1;
         end
         root = '0;
         for (int b = KEY_W - 1; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sq_sum) begin
               root = trial;
            end
         end
         return root[KEY_W-1:0];
      endfunction

      // accepted vertex: widen the box, and on the last vertex queue its key
      function void note_vertex(pdk_req_type v);
         coord_type axis_val[3];
         axis_val[0] = v.x_coord;
         axis_val[1] = v.y_coord;
         axis_val[2] = v.z_coord;
         for (int a = 0; a < NUM_AXES; a++) begin
            if (opens_polygon) begin
               box_low[a]  = axis_val[a];
               box_high[a] = axis_val[a];
            end else begin
               if (axis_val[a] < box_low[a]) box_low[a] = axis_val[a];
               if (axis_val[a] > box_high[a]) box_high[a] = axis_val[a];
            end
         end
         if (v.last_vertex) begin
            keys_due.push_back('{depth_key: depth_of_box(),
                                 object_out: v.object_tag,
                                 poly_out: v.poly_tag});
         end
         opens_polygon = v.last_vertex;
      endfunction

      // accepted result against the oldest key due
      function void check_result(pdk_rsp_type r);
         pdk_rsp_type want;
         if (keys_due.size() == 0) begin
            $error("result with no polygon finished: depth_key %h object %h poly %h",
                   r.depth_key, r.object_out, r.poly_out);
            failures++;
            return;
         end
         want = keys_due.pop_front();
         if (r.depth_key !== want.depth_key) begin
            $error("depth_key: expected %h, actual %h", want.depth_key, r.depth_key);
            failures++;
         end
         if (r.object_out !== want.object_out) begin
            $error("object_out: expected %h, actual %h", want.object_out, r.object_out);
            failures++;
         end
         if (r.poly_out !== want.poly_out) begin
            $error("poly_out: expected %h, actual %h", want.poly_out, r.poly_out);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pdk_req_type req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   pdk_rsp_type rsp_item;

   depth_key_board board;
   bit             req_fired;
   bit             rsp_fired;
   int             quiet_cycles;
   int             sender_idle_pct;
   int             receiver_stall_pct;
   bit             hold_request;
   int             hold_left;

   polygon_depth_key_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // monitor and watchdog on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
         rsp_fired = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fired = req_valid && !req_stall;
         rsp_fired = rsp_valid && !rsp_stall;
         if (req_fired) board.note_vertex(req_item);
         if (rsp_fired) board.check_result(rsp_item);
         quiet_cycles = (req_fired || rsp_fired) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   function automatic pdk_req_type make_vertex(coord_type x, coord_type y, coord_type z,
                                               int obj, int poly, bit last);
      pdk_req_type v;
      v.x_coord     = x;
      v.y_coord     = y;
      v.z_coord     = z;
      v.object_tag  = obj[OBJ_W-1:0];
      v.poly_tag    = poly[POLY_W-1:0];
      v.last_vertex = last;
      return v;
   endfunction

   // coordinate mix: any value, small, near the extremes, whole units
   function automatic coord_type rand_coord();
      coord_type c;
      case ($urandom_range(3))
         0: c = coord_type'({$urandom, $urandom});
         1: c = coord_type'(int'($urandom_range(2000000)) - 1000000);
         2: begin
            if ($urandom_range(1)) c = COORD_MAX - coord_type'($urandom_range(255));
            else c = COORD_MIN + coord_type'($urandom_range(255));
         end
         default: c = coord_type'((int'($urandom_range(400)) - 200) * ONE_Q16);
      endcase
      return c;
   endfunction

   // offer one vertex, after a random gap, and hold it until taken
   task automatic send_vertex(input pdk_req_type v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= v;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_fired);
   endtask

   // one polygon of random size, mostly short
   task automatic send_polygon(output int size);
      int pick;
      pick = $urandom_range(9);
      if (pick < 3) size = 1;
      else if (pick < 7) size = $urandom_range(4, 2);
      else if (pick < 9) size = $urandom_range(8, 5);
      else size = $urandom_range(24, 9);
      for (int k = 0; k < size; k++) begin
         send_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                 $urandom_range(15), $urandom_range(4095), k == size - 1));
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int vertices);
      int sent;
      int size;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < vertices) begin
         send_polygon(size);
         sent += size;
      end
   endtask

   // directed cases: extremes, rounding of odd sums, tags, single vertices
   task automatic send_directed();
      send_vertex(make_vertex(0, 0, 0, 0, 0, 1'b1));
      send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 15, 4095, 1'b1));
      send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 5, 1234, 1'b1));
      // odd negative sums round toward minus infinity
      send_vertex(make_vertex(COORD_MIN, COORD_MAX, 0, 3, 100, 1'b0));
      send_vertex(make_vertex(COORD_MAX, COORD_MIN, -1, 9, 200, 1'b1));
      // odd positive sums
      send_vertex(make_vertex(1, 3, 5, 4, 300, 1'b0));
      send_vertex(make_vertex(2, 4, 8, 6, 301, 1'b1));
      // only the tags of the last vertex count
      send_vertex(make_vertex(16 * ONE_Q16, -16 * ONE_Q16, 5 * ONE_Q16, 15, 4095, 1'b0));
      send_vertex(make_vertex(-32 * ONE_Q16, 48 * ONE_Q16, 0, 15, 4095, 1'b0));
      send_vertex(make_vertex(4 * ONE_Q16, 0, -7 * ONE_Q16, 0, 0, 1'b1));
      // box widens on both sides over several vertices
      send_vertex(make_vertex(0, 0, 0, 1, 1, 1'b0));
      send_vertex(make_vertex(5 * ONE_Q16, -3 * ONE_Q16, 2 * ONE_Q16, 1, 1, 1'b0));
      send_vertex(make_vertex(-7 * ONE_Q16, 9 * ONE_Q16, -4 * ONE_Q16, 1, 1, 1'b0));
      send_vertex(make_vertex(ONE_Q16, ONE_Q16, ONE_Q16, 2, 77, 1'b1));
      // single vertex at an exact distance, then a bit pattern mix
      send_vertex(make_vertex(-3 * ONE_Q16, 4 * ONE_Q16, 0, 10, 2730, 1'b1));
      send_vertex(make_vertex(-1, 1, coord_type'(32'hAAAA_AAAA), 5, 1365, 1'b1));
   endtask

   // reset, stimulus phases, drain and verdict
   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      hold_request = 1'b0;
      sender_idle_pct = 26;
      receiver_stall_pct = 76;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_directed();
      run_phase(26, 76, 640);
      run_phase(76, 26, 640);
      // long receiver hold-off while vertices keep coming
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b1;
      run_phase(0, 0, 650);
      req_valid <= 1'b0;

      while (board.keys_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/pdk_pkg.sv
sv/pdk_queue.sv
sv/pdk_front.sv
sv/pdk_back.sv
sv/polygon_depth_key_core.sv
tb/sv/polygon_depth_key_core_test.sv
